// ===== rtl/crcdk_pkg.sv =====
// Package for the CRC-32 decimal key block.
// Holds controller states, command/status structs, CRC constants and byte fold.
// No dependencies.
package crcdk_pkg;

  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
  localparam int          NUM_DIGITS = 10;
  localparam int          BCD_W      = 4 * NUM_DIGITS;
  localparam int          BIN_W      = 32;
  localparam int          CNT_W      = $clog2(BIN_W);
  localparam int          NDIG_W     = $clog2(NUM_DIGITS + 1);
  localparam logic [5:0]  ASCII_ZERO = 6'd48;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic upd;    // fold request into running CRC
    logic load;   // end of text: start conversion, restart CRC
    logic conv;   // one binary-to-BCD step
    logic skip;   // drop a leading zero digit
    logic emit;   // digit taken downstream
  } cmd_t;

  typedef struct packed {
    logic conv_last;
    logic lead_zero;
    logic last_digit;
  } sts_t;

  function automatic logic [31:0] crc_fold(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

endpackage

// ===== rtl/crc32_decimal_key.sv =====
// After an end-of-text request the controller runs 32 BCD steps, one skip check and one skip step per leading
// zero; digits then leave at one per cycle when out_tready is high.
// Throughput: one text byte per cycle while idle; after an end of text no byte is taken until the
// last digit is emitted, as the bit-serial binary-to-BCD converter is busy. Reset: rst_n synchronous, active low;
// CRC returns to all ones and the controller to idle.
// Top level of the CRC-32 decimal key block; depends on crcdk_pkg, crcdk_ctrl, crcdk_dp.
module crc32_decimal_key
  import crcdk_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] byte_value
  input  logic       in_tuser,   // [0] byte_present
  input  logic       in_tlast,   // end_of_text
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [5:0] digit_char, [7:6] zero
  output logic       out_tlast   // last_digit
);

  cmd_t       cmd;
  sts_t       sts;
  logic [5:0] digit_char;

  crcdk_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  crcdk_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_value   (in_tdata),
    .byte_present (in_tuser),
    .cmd          (cmd),
    .sts          (sts),
    .digit_char   (digit_char)
  );

  assign out_tdata = {2'b00, digit_char};
  assign out_tlast = sts.last_digit;

endmodule

// ===== rtl/crcdk_ctrl.sv =====
// Controller for the CRC-32 decimal key block.
// Sequences accept, BCD conversion, leading-zero skip and digit emission.
// Depends on crcdk_pkg.
module crcdk_ctrl
  import crcdk_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic in_tlast,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   fire;

  assign fire = in_tvalid && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (fire && in_tlast) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (sts.conv_last) state_nxt = ST_SKIP;
      end
      ST_SKIP: begin
        if (!sts.lead_zero) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_tready && sts.last_digit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.upd   = fire;
        cmd.load  = fire && in_tlast;
      end
      ST_CONV: begin
        cmd.conv = 1'b1;
      end
      ST_SKIP: begin
        cmd.skip = sts.lead_zero;
      end
      ST_EMIT: begin
        out_tvalid = 1'b1;
        cmd.emit   = out_tready;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

`ifndef SYNTH
  a_end_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_tvalid && in_tlast) |=> (state_r == ST_CONV))
    else $error("end of text did not start conversion");
  a_conv_to_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV && sts.conv_last) |=> (state_r == ST_SKIP))
    else $error("conversion did not finish after last step");
  a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && !out_tready) |=> (state_r == ST_EMIT && $stable(sts.last_digit)))
    else $error("stalled digit was dropped");
`endif

endmodule

// ===== rtl/crcdk_dp.sv =====
// Datapath for the CRC-32 decimal key block.
// Running CRC, double-dabble binary-to-BCD converter and digit shifter.
// Depends on crcdk_pkg.
module crcdk_dp
  import crcdk_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] byte_value,
  input  logic       byte_present,
  input  cmd_t       cmd,
  output sts_t       sts,
  output logic [5:0] digit_char
);

  logic [31:0]       crc_r;
  logic [31:0]       crc_new;
  logic [BIN_W-1:0]  bin_r;
  logic [BCD_W-1:0]  bcd_r;
  logic [BCD_W-1:0]  bcd_adj;
  logic [CNT_W-1:0]  cnt_r;
  logic [NDIG_W-1:0] ndig_r;
  logic [3:0]        top_digit;

  assign crc_new   = byte_present ? crc_fold(crc_r, byte_value) : crc_r;
  assign top_digit = bcd_r[BCD_W-1 -: 4];

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3
                                                      : bcd_r[i*4 +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= CRC_INIT;
      cnt_r  <= '0;
      ndig_r <= '0;
    end else if (cmd.load) begin
      crc_r  <= CRC_INIT;
      cnt_r  <= '0;
      ndig_r <= NDIG_W'(NUM_DIGITS);
    end else if (cmd.upd) begin
      crc_r <= crc_new;
    end else if (cmd.conv) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (cmd.skip || cmd.emit) begin
      ndig_r <= ndig_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin_r <= crc_new;
      bcd_r <= '0;
    end else if (cmd.conv) begin
      bcd_r <= {bcd_adj[BCD_W-2:0], bin_r[BIN_W-1]};
      bin_r <= {bin_r[BIN_W-2:0], 1'b0};
    end else if (cmd.skip || cmd.emit) begin
      bcd_r <= {bcd_r[BCD_W-5:0], 4'd0};
    end
  end

  assign sts.conv_last  = (cnt_r == CNT_W'(BIN_W - 1));
  assign sts.last_digit = (ndig_r == NDIG_W'(1));
  assign sts.lead_zero  = (top_digit == 4'd0) && (ndig_r != NDIG_W'(1));
  assign digit_char     = ASCII_ZERO + {2'b00, top_digit};

endmodule

// ===== dv/tb_crc32_decimal_key.sv =====
// Testbench for crc32_decimal_key: a directed table, then random texts checked digit by digit
// against a CRC-32 and decimal-digit predictor, with random idling on both stream sides.
// Depends on crcdk_pkg and crc32_decimal_key.
`timescale 1ns / 100ps

module tb_crc32_decimal_key;
  import crcdk_pkg::CRC_POLY;
  import crcdk_pkg::CRC_INIT;
  import crcdk_pkg::ASCII_ZERO;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [5:0] ch;
    logic       last;
  } digit_t;

  typedef struct {
    logic [7:0] b;
    bit         present;
    bit         eot;
    string      want;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'd0;   // [7:0] byte_value
  logic       in_tuser = 1'b0;   // [0] byte_present
  logic       in_tlast = 1'b0;   // end_of_text
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;         // [5:0] digit_char, [7:6] zero
  logic       out_tlast;         // last_digit

  logic [31:0] crc_state;
  digit_t      pending_digits[$];
  int          errors = 0;
  int          cycles = 0;
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  bit          hold_on = 1'b0;
  int          hold_cnt = 0;

  dir_row_t dir_rows [22] = '{
    '{8'h00, 1'b0, 1'b1, "4294967295"},  // empty text right after reset
    '{8'hFF, 1'b1, 1'b0, ""},
    '{8'hFF, 1'b1, 1'b0, ""},
    '{8'hFF, 1'b1, 1'b0, ""},
    '{8'hFF, 1'b1, 1'b1, "0"},           // byte with end, CRC comes out zero
    '{8'h5A, 1'b0, 1'b0, ""},            // no byte, no end
    '{8'h00, 1'b0, 1'b1, "4294967295"},
    '{8'h00, 1'b1, 1'b1, ""},            // zero byte ends a text
    '{8'h00, 1'b1, 1'b0, ""},
    '{8'h00, 1'b1, 1'b0, ""},
    '{8'hA5, 1'b0, 1'b0, ""},
    '{8'h00, 1'b1, 1'b1, ""},
    '{8'h80, 1'b1, 1'b0, ""},
    '{8'h01, 1'b1, 1'b1, ""},
    '{8'h55, 1'b1, 1'b0, ""},
    '{8'hAA, 1'b1, 1'b0, ""},
    '{8'h7F, 1'b1, 1'b1, ""},
    '{8'h31, 1'b1, 1'b0, ""},
    '{8'h32, 1'b1, 1'b0, ""},
    '{8'hFE, 1'b0, 1'b1, ""},            // end without a byte after bytes
    '{8'hFF, 1'b1, 1'b1, ""},
    '{8'h00, 1'b0, 1'b1, "4294967295"}
  };

  crc32_decimal_key dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("crc32_decimal_key test failed");
      $finish;
    end
  end

  function automatic logic [31:0] crc_with_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CRC_POLY;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

  task automatic push_crc_digits(input logic [31:0] v);
    logic [3:0] d [10];
    int         n;
    n = 0;
    do begin
      d[n] = 4'(v % 10);
      v = v / 10;
      n++;
    end while (v != 0 && n < 10);
    for (int k = n - 1; k >= 0; k--) begin
      pending_digits.push_back('{ASCII_ZERO + 6'(d[k]), k == 0});
    end
  endtask

  task automatic push_typed_digits(input string s);
    byte c;
    for (int k = 0; k < s.len(); k++) begin
      c = s[k];
      pending_digits.push_back('{c[5:0], k == s.len() - 1});
    end
  endtask

  task automatic flag_mismatch(input string what);
    $display("ERROR @%0t: %s", $realtime, what);
    errors++;
  endtask

  task automatic send_request(input logic [7:0] b, input bit present, input bit eot,
                              input string want);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      in_tuser  <= 1'($urandom);
      in_tlast  <= 1'($urandom);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= present;
    in_tlast  <= eot;
    do @(posedge clk); while (!in_tready);
    if (present) begin
      crc_state = crc_with_byte(crc_state, b);
    end
    if (eot) begin
      if (want.len() != 0) begin
        push_typed_digits(want);
      end else begin
        push_crc_digits(crc_state);
      end
      crc_state = CRC_INIT;
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_digits.size() != 0) @(posedge clk);
  endtask

  // random texts; items with neither byte nor end do not count
  task automatic run_random_texts(input int n_items);
    int count;
    int len;
    count = 0;
    while (count < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_request(8'($urandom), 1'b0, 1'b0, "");
      end else if ($urandom_range(19) == 0) begin
        repeat (4) send_request(8'hFF, 1'b1, 1'b0, "");
        send_request(8'($urandom), 1'b0, 1'b1, "");
        count += 5;
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(9) == 0) begin
            send_request(8'($urandom), 1'b0, 1'b0, "");
          end else begin
            send_request(8'($urandom), 1'b1, 1'b0, "");
            count++;
          end
        end
        send_request(8'($urandom), 1'($urandom), 1'b1, "");
        count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_on && hold_cnt < HOLD_CYCLES) begin
      hold_cnt   <= hold_cnt + 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    digit_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_digits.size() == 0) begin
        flag_mismatch($sformatf("digit 0x%02h arrived with none expected", out_tdata));
      end else begin
        want = pending_digits.pop_front();
        if (out_tdata[5:0] !== want.ch) begin
          flag_mismatch($sformatf("digit_char %0d, want %0d", out_tdata[5:0], want.ch));
        end
        if (out_tlast !== want.last) begin
          flag_mismatch($sformatf("last_digit %0b, want %0b", out_tlast, want.last));
        end
        if (out_tdata[7:6] !== 2'b00) begin
          flag_mismatch($sformatf("tdata pad bits %02b, want 00", out_tdata[7:6]));
        end
      end
    end
  end

  initial begin
    crc_state = CRC_INIT;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    snd_idle_pct = 19;
    rcv_idle_pct = 53;
    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].b, dir_rows[i].present, dir_rows[i].eot, dir_rows[i].want);
    end
    wait_drained();

    hold_on = 1'b1;
    run_random_texts(80);
    snd_idle_pct = 53;
    rcv_idle_pct = 19;
    run_random_texts(80);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_random_texts(80);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("crc32_decimal_key test passed");
    end else begin
      $display("crc32_decimal_key test failed");
    end
    $finish;
  end

endmodule

// ===== crc32_decimal_key.f =====
rtl/crcdk_pkg.sv
rtl/crcdk_ctrl.sv
rtl/crcdk_dp.sv
rtl/crc32_decimal_key.sv
dv/tb_crc32_decimal_key.sv
